FILE: src/nnds_pkg.sv
// ----------------------------------------------------------------------------
// nnds_pkg: shared definitions for the nearest-neighbor downscaler
// Field widths, register indexes, reset values and color masks used by the
// RGB565 to RGB888 downscaling unit.
// ----------------------------------------------------------------------------
package nnds_pkg;

    // Fixed field widths.
    localparam int CFG_W   = 13;
    localparam int PIX_W   = 16;
    localparam int COLOR_W = 8;
    localparam int POS_W   = 12;
    localparam int IDX_W   = 2;

    // Configuration register indexes.
    typedef enum logic [IDX_W-1:0] {
        CFG_SOURCE_WIDTH  = 2'd0,
        CFG_SOURCE_HEIGHT = 2'd1,
        CFG_DEST_WIDTH    = 2'd2,
        CFG_DEST_HEIGHT   = 2'd3
    } t_cfg_idx;

    // Register values after reset.
    localparam logic [CFG_W-1:0] RST_SOURCE_WIDTH  = 13'd1920;
    localparam logic [CFG_W-1:0] RST_SOURCE_HEIGHT = 13'd1080;
    localparam logic [CFG_W-1:0] RST_DEST_WIDTH    = 13'd224;
    localparam logic [CFG_W-1:0] RST_DEST_HEIGHT   = 13'd224;

    // RGB565 to RGB888 masking, no bit replication.
    localparam logic [COLOR_W-1:0] RED_MASK    = 8'hF8;
    localparam logic [COLOR_W-1:0] GREEN_MASK  = 8'hFC;
    localparam logic [COLOR_W-1:0] BLUE_MASK   = 8'hF8;
    localparam int                 RED_SHIFT   = 8;
    localparam int                 GREEN_SHIFT = 3;
    localparam int                 BLUE_SHIFT  = 3;

endpackage

FILE: src/nearest_neighbor_downscale_rgb565_unit.sv
// ----------------------------------------------------------------------------
// nearest_neighbor_downscale_rgb565_unit: streaming nearest-neighbor scaler
// Keeps the source pixels that land on output grid points and emits them as
// RGB888, tracking the sample positions with running products.
// ----------------------------------------------------------------------------
//
//  Channel   Direction  Handshake                 Payload
//  -------   ---------  ------------------------  ----------------------------
//  input     in         i_in_valid / o_in_stall   i_pixel, i_frame_start
//  output    out        o_out_valid / i_out_stall o_red, o_green, o_blue,
//                                                 o_out_col, o_out_row,
//                                                 o_frame_last
//  config    in         i_cfg_we                  i_cfg_index, i_cfg_data
//
// One source pixel per clock is taken while o_in_stall is low. A pixel passes
// an input register and the counter update into the output register, where a
// kept pixel is offered. The counter and running-product update bounds the
// rate. Reset clears the counters and loads the default sizes. A stalled
// output holds its result; the input register stalls only when it is full and
// the output register cannot be refilled.
module nearest_neighbor_downscale_rgb565_unit #(
    parameter int MAX_DIM = 4096
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    // Configuration write port
    input  logic                            i_cfg_we,
    input  logic [nnds_pkg::IDX_W-1:0]      i_cfg_index,
    input  logic [nnds_pkg::CFG_W-1:0]      i_cfg_data,
    // Source pixel stream
    input  logic                            i_in_valid,
    output logic                            o_in_stall,
    input  logic [nnds_pkg::PIX_W-1:0]      i_pixel,
    input  logic                            i_frame_start,
    // Output pixel stream
    output logic                            o_out_valid,
    input  logic                            i_out_stall,
    output logic [nnds_pkg::COLOR_W-1:0]    o_red,
    output logic [nnds_pkg::COLOR_W-1:0]    o_green,
    output logic [nnds_pkg::COLOR_W-1:0]    o_blue,
    output logic [nnds_pkg::POS_W-1:0]      o_out_col,
    output logic [nnds_pkg::POS_W-1:0]      o_out_row,
    output logic                            o_frame_last
);

    // Largest usable dimension: bounded by the parameter and the register.
    localparam int CFG_MAX = (1 << nnds_pkg::CFG_W) - 1;
    localparam int DIM_MAX = (MAX_DIM < CFG_MAX) ? MAX_DIM : CFG_MAX;
    localparam int CW      = $clog2(DIM_MAX + 1);
    localparam int PW      = $clog2(DIM_MAX * DIM_MAX + 1);
    localparam logic [nnds_pkg::CFG_W-1:0] DIM_LIM = nnds_pkg::CFG_W'(DIM_MAX);

    // Configuration registers
    logic [nnds_pkg::CFG_W-1:0] r_source_width, r_source_height;
    logic [nnds_pkg::CFG_W-1:0] r_dest_width, r_dest_height;

    // Input register
    logic                       r_in_valid, n_in_valid;
    logic [nnds_pkg::PIX_W-1:0] r_pixel;
    logic                       r_frame_start;

    // Position counters and running products
    logic [CW-1:0] r_src_col, r_src_row, r_dst_col, r_dst_row;
    logic [PW-1:0] r_col_sprod, r_col_dprod, r_row_sprod, r_row_dprod;
    logic [CW-1:0] n_src_col, n_src_row, n_dst_col, n_dst_row;
    logic [PW-1:0] n_col_sprod, n_col_dprod, n_row_sprod, n_row_dprod;

    // Output register
    logic                         r_out_valid, n_out_valid;
    logic [nnds_pkg::COLOR_W-1:0] r_red, r_green, r_blue;
    logic [nnds_pkg::POS_W-1:0]   r_out_col, r_out_row;
    logic                         r_frame_last;

    // Handshake and datapath signals
    logic                       in_accept, out_free, fire, keep;
    logic [nnds_pkg::CFG_W-1:0] sw_c, sh_c, dw_c, dh_c;
    logic [CW-1:0]              sw, sh, dw, dh;
    logic [CW-1:0]              src_col, src_row, dst_col, dst_row;
    logic [PW-1:0]              col_sprod, col_dprod, row_sprod, row_dprod;
    logic [PW:0]                col_limit, row_limit;
    logic                       col_hit, row_hit;
    logic [CW:0]                src_col_inc, src_row_inc;

    // Clamp sizes: sources to 1..DIM_MAX, destinations to 1..source size.
    always_comb begin
        sw_c = (r_source_width == '0) ? nnds_pkg::CFG_W'(1) :
               (r_source_width > DIM_LIM) ? DIM_LIM : r_source_width;
        sh_c = (r_source_height == '0) ? nnds_pkg::CFG_W'(1) :
               (r_source_height > DIM_LIM) ? DIM_LIM : r_source_height;
        dw_c = (r_dest_width == '0) ? nnds_pkg::CFG_W'(1) :
               (r_dest_width > sw_c) ? sw_c : r_dest_width;
        dh_c = (r_dest_height == '0) ? nnds_pkg::CFG_W'(1) :
               (r_dest_height > sh_c) ? sh_c : r_dest_height;
        sw = sw_c[CW-1:0];
        sh = sh_c[CW-1:0];
        dw = dw_c[CW-1:0];
        dh = dh_c[CW-1:0];
    end

    // Stage handshake: the input register drains when the output can load.
    assign out_free   = !r_out_valid || !i_out_stall;
    assign fire       = r_in_valid && out_free;
    assign o_in_stall = r_in_valid && !out_free;
    assign in_accept  = i_in_valid && !o_in_stall;

    always_comb begin
        n_in_valid = r_in_valid;
        if (in_accept) begin
            n_in_valid = 1'b1;
        end else if (fire) begin
            n_in_valid = 1'b0;
        end
    end

    // Sample decision and counter update for the pixel in the input register.
    always_comb begin
        // A frame start realigns everything before the pixel is judged.
        src_col   = r_frame_start ? '0 : r_src_col;
        src_row   = r_frame_start ? '0 : r_src_row;
        dst_col   = r_frame_start ? '0 : r_dst_col;
        dst_row   = r_frame_start ? '0 : r_dst_row;
        col_sprod = r_frame_start ? '0 : r_col_sprod;
        col_dprod = r_frame_start ? '0 : r_col_dprod;
        row_sprod = r_frame_start ? '0 : r_row_sprod;
        row_dprod = r_frame_start ? '0 : r_row_dprod;

        col_limit = {1'b0, col_sprod} + (PW+1)'(dw);
        row_limit = {1'b0, row_sprod} + (PW+1)'(dh);
        col_hit   = (dst_col < dw) && (col_sprod <= col_dprod) &&
                    ({1'b0, col_dprod} < col_limit);
        row_hit   = (dst_row < dh) && (row_sprod <= row_dprod) &&
                    ({1'b0, row_dprod} < row_limit);
        keep      = col_hit && row_hit;

        // Column advance.
        n_dst_col   = col_hit ? dst_col + CW'(1) : dst_col;
        n_col_dprod = col_hit ? col_dprod + PW'(sw) : col_dprod;
        src_col_inc = {1'b0, src_col} + (CW+1)'(1);
        n_src_col   = src_col_inc[CW-1:0];
        n_col_sprod = col_sprod + PW'(dw);
        n_src_row   = src_row;
        n_dst_row   = dst_row;
        n_row_sprod = row_sprod;
        n_row_dprod = row_dprod;
        src_row_inc = {1'b0, src_row} + (CW+1)'(1);

        // End of row, and end of frame behind it.
        if (src_col_inc >= (CW+1)'(sw)) begin
            n_src_col   = '0;
            n_dst_col   = '0;
            n_col_sprod = '0;
            n_col_dprod = '0;
            n_dst_row   = row_hit ? dst_row + CW'(1) : dst_row;
            n_row_dprod = row_hit ? row_dprod + PW'(sh) : row_dprod;
            n_src_row   = src_row_inc[CW-1:0];
            n_row_sprod = row_sprod + PW'(dh);
            if (src_row_inc >= (CW+1)'(sh)) begin
                n_src_row   = '0;
                n_dst_row   = '0;
                n_row_sprod = '0;
                n_row_dprod = '0;
            end
        end
    end

    // Output valid: set by a kept pixel, cleared when the result is taken.
    always_comb begin
        n_out_valid = r_out_valid && i_out_stall;
        if (fire) begin
            n_out_valid = keep;
        end
    end

    // Control state, counters and configuration registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid      <= 1'b0;
            r_out_valid     <= 1'b0;
            r_src_col       <= '0;
            r_src_row       <= '0;
            r_dst_col       <= '0;
            r_dst_row       <= '0;
            r_col_sprod     <= '0;
            r_col_dprod     <= '0;
            r_row_sprod     <= '0;
            r_row_dprod     <= '0;
            r_source_width  <= nnds_pkg::RST_SOURCE_WIDTH;
            r_source_height <= nnds_pkg::RST_SOURCE_HEIGHT;
            r_dest_width    <= nnds_pkg::RST_DEST_WIDTH;
            r_dest_height   <= nnds_pkg::RST_DEST_HEIGHT;
        end else begin
            r_in_valid  <= n_in_valid;
            r_out_valid <= n_out_valid;
            if (fire) begin
                r_src_col   <= n_src_col;
                r_src_row   <= n_src_row;
                r_dst_col   <= n_dst_col;
                r_dst_row   <= n_dst_row;
                r_col_sprod <= n_col_sprod;
                r_col_dprod <= n_col_dprod;
                r_row_sprod <= n_row_sprod;
                r_row_dprod <= n_row_dprod;
            end
            if (i_cfg_we) begin
                unique case (nnds_pkg::t_cfg_idx'(i_cfg_index))
                    nnds_pkg::CFG_SOURCE_WIDTH:  r_source_width  <= i_cfg_data;
                    nnds_pkg::CFG_SOURCE_HEIGHT: r_source_height <= i_cfg_data;
                    nnds_pkg::CFG_DEST_WIDTH:    r_dest_width    <= i_cfg_data;
                    nnds_pkg::CFG_DEST_HEIGHT:   r_dest_height   <= i_cfg_data;
                    default:                     r_source_width  <= r_source_width;
                endcase
            end
        end
    end

    // Input payload register.
    always_ff @(posedge i_clk) begin
        if (in_accept) begin
            r_pixel       <= i_pixel;
            r_frame_start <= i_frame_start;
        end
    end

    // Output payload register: masked RGB888 and output position.
    always_ff @(posedge i_clk) begin
        if (fire && keep) begin
            r_red        <= nnds_pkg::COLOR_W'(r_pixel >> nnds_pkg::RED_SHIFT)
                            & nnds_pkg::RED_MASK;
            r_green      <= nnds_pkg::COLOR_W'(r_pixel >> nnds_pkg::GREEN_SHIFT)
                            & nnds_pkg::GREEN_MASK;
            r_blue       <= nnds_pkg::COLOR_W'(r_pixel << nnds_pkg::BLUE_SHIFT)
                            & nnds_pkg::BLUE_MASK;
            r_out_col    <= nnds_pkg::POS_W'(dst_col);
            r_out_row    <= nnds_pkg::POS_W'(dst_row);
            r_frame_last <= (dst_col == dw - CW'(1)) && (dst_row == dh - CW'(1));
        end
    end

    assign o_out_valid  = r_out_valid;
    assign o_red        = r_red;
    assign o_green      = r_green;
    assign o_blue       = r_blue;
    assign o_out_col    = r_out_col;
    assign o_out_row    = r_out_row;
    assign o_frame_last = r_frame_last;

endmodule
